FILE: rtl/lis_pkg.sv
`default_nettype none

package lis_pkg;

  localparam int COUNT_BITS_DEF = 24;
  localparam int WC_W           = 24;
  localparam int STAMP_W        = 32;
  localparam int SUM_W          = 56;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 32;
  localparam int STEP_W         = 4;
  localparam int DCNT_W         = $clog2(SUM_W);

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_TIMER_MAX    = CFG_IDX_W'(1);

  typedef enum logic [2:0] {
    OP_NONE,
    OP_RESTART,
    OP_UPDATE,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_IS_MARK,
    COND_NO_CLOSE,
    COND_DIV_MORE,
    COND_OUT_BUSY
  } cond_t;

  typedef enum logic [STEP_W-1:0] {
    ST_FETCH    = STEP_W'(0),
    ST_DISPATCH = STEP_W'(1),
    ST_RESTART  = STEP_W'(2),
    ST_UPDATE   = STEP_W'(3),
    ST_CHECK    = STEP_W'(4),
    ST_DIV_INIT = STEP_W'(5),
    ST_DIV_STEP = STEP_W'(6),
    ST_WAIT_OUT = STEP_W'(7),
    ST_EMIT     = STEP_W'(8)
  } step_t;

  typedef struct packed {
    logic  accept;
    op_t   op;
    cond_t cond;
    step_t target;
  } uword_t;

  typedef struct packed {
    logic accept;
    op_t  op;
  } seq_ctl_t;

  typedef struct packed {
    logic is_mark;
    logic no_close;
    logic div_more;
    logic out_busy;
  } dp_status_t;

  // control store: taken condition jumps to target, otherwise next step
  function automatic uword_t ucode(input step_t step);
    uword_t w;
    case (step)
      ST_FETCH:    w = '{1'b1, OP_NONE,     COND_NO_INPUT, ST_FETCH};
      ST_DISPATCH: w = '{1'b0, OP_NONE,     COND_IS_MARK,  ST_UPDATE};
      ST_RESTART:  w = '{1'b0, OP_RESTART,  COND_ALWAYS,   ST_FETCH};
      ST_UPDATE:   w = '{1'b0, OP_UPDATE,   COND_NEVER,    ST_FETCH};
      ST_CHECK:    w = '{1'b0, OP_NONE,     COND_NO_CLOSE, ST_WAIT_OUT};
      ST_DIV_INIT: w = '{1'b0, OP_DIV_INIT, COND_NEVER,    ST_FETCH};
      ST_DIV_STEP: w = '{1'b0, OP_DIV_STEP, COND_DIV_MORE, ST_DIV_STEP};
      ST_WAIT_OUT: w = '{1'b0, OP_NONE,     COND_OUT_BUSY, ST_WAIT_OUT};
      ST_EMIT:     w = '{1'b0, OP_EMIT,     COND_ALWAYS,   ST_FETCH};
      default:     w = '{1'b0, OP_NONE,     COND_ALWAYS,   ST_FETCH};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/loop_interval_statistics.sv
// channel  | direction | handshake            | payload
// ---------+-----------+----------------------+------------------------------------------
// in_      | input     | in_valid / in_ready   | cmd, timestamp
// out_     | output    | out_valid / out_ready | interval, window_done, window_mean,
//          |           |                      | window_total, window_max, global_max
// cfg_     | input     | cfg_valid / cfg_ready | index, data
//
// one item at a time under a microcoded step sequencer
// restart: fetch, dispatch, restart; mark without window close: fetch, dispatch, update, check,
// wait_out, emit to the output register; a closing mark adds div_init and the 56-step serial divider for the mean
// reset is synchronous; no clearing pass, the block takes items right after reset
// a result waits in the output register; the next beat is accepted meanwhile, and
// the sequencer holds before loading its result until the register is free
`default_nettype none

module loop_interval_statistics #(
  parameter int COUNT_BITS = lis_pkg::COUNT_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lis_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [lis_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic                           in_cmd,
  input  wire logic [lis_pkg::STAMP_W-1:0]    in_timestamp,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [lis_pkg::STAMP_W-1:0]         out_interval,
  output logic                                out_window_done,
  output logic [lis_pkg::STAMP_W-1:0]         out_window_mean,
  output logic [lis_pkg::SUM_W-1:0]           out_window_total,
  output logic [lis_pkg::STAMP_W-1:0]         out_window_max,
  output logic [lis_pkg::STAMP_W-1:0]         out_global_max
);
  import lis_pkg::*;

  seq_ctl_t   ctl;
  dp_status_t status;

  assign cfg_ready = 1'b1;
  assign in_ready  = ctl.accept;

  lis_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .status   (status),
    .ctl      (ctl)
  );

  lis_dp #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .status           (status),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_cmd           (in_cmd),
    .in_timestamp     (in_timestamp),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_interval     (out_interval),
    .out_window_done  (out_window_done),
    .out_window_mean  (out_window_mean),
    .out_window_total (out_window_total),
    .out_window_max   (out_window_max),
    .out_global_max   (out_global_max)
  );

endmodule

`default_nettype wire

FILE: rtl/lis_seq.sv
`default_nettype none

module lis_seq (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire lis_pkg::dp_status_t status,
  output lis_pkg::seq_ctl_t        ctl
);
  import lis_pkg::*;

  step_t  step_r;
  step_t  step_nxt;
  uword_t word;
  logic   taken;

  assign word       = ucode(step_r);
  assign ctl.accept = word.accept;
  assign ctl.op     = word.op;

  always_comb begin
    case (word.cond)
      COND_NEVER:    taken = 1'b0;
      COND_ALWAYS:   taken = 1'b1;
      COND_NO_INPUT: taken = ~in_valid;
      COND_IS_MARK:  taken = status.is_mark;
      COND_NO_CLOSE: taken = status.no_close;
      COND_DIV_MORE: taken = status.div_more;
      COND_OUT_BUSY: taken = status.out_busy;
      default:       taken = 1'b1;
    endcase
    step_nxt = taken ? word.target : step_t'(step_r + STEP_W'(1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_FETCH;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/lis_dp.sv
`default_nettype none

module lis_dp #(
  parameter int COUNT_BITS = lis_pkg::COUNT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire lis_pkg::seq_ctl_t             ctl,
  output lis_pkg::dp_status_t                status,
  input  wire logic                          cfg_valid,
  input  wire logic [lis_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lis_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                          in_valid,
  input  wire logic                          in_cmd,
  input  wire logic [lis_pkg::STAMP_W-1:0]   in_timestamp,
  input  wire logic                          out_ready,
  output logic                               out_valid,
  output logic [lis_pkg::STAMP_W-1:0]        out_interval,
  output logic                               out_window_done,
  output logic [lis_pkg::STAMP_W-1:0]        out_window_mean,
  output logic [lis_pkg::SUM_W-1:0]          out_window_total,
  output logic [lis_pkg::STAMP_W-1:0]        out_window_max,
  output logic [lis_pkg::STAMP_W-1:0]        out_global_max
);
  import lis_pkg::*;

  localparam int CMP_W = (COUNT_BITS > WC_W) ? COUNT_BITS : WC_W;

  logic [WC_W-1:0]       wc_r;
  logic [STAMP_W-1:0]    tmax_r;
  logic                  cmd_r;
  logic [STAMP_W-1:0]    stamp_r;
  logic [STAMP_W-1:0]    last_r;
  logic [COUNT_BITS-1:0] count_r;
  logic [SUM_W-1:0]      sum_r;
  logic [STAMP_W-1:0]    wpeak_r;
  logic [STAMP_W-1:0]    gpeak_r;
  logic [STAMP_W-1:0]    iv_r;
  logic [STAMP_W-1:0]    wmax_r;
  logic                  done_r;
  logic [SUM_W-1:0]      total_r;
  logic [SUM_W-1:0]      quo_r;
  logic [WC_W-1:0]       rem_r;
  logic [DCNT_W-1:0]     dcnt_r;
  logic                  out_valid_r;

  logic [STAMP_W-1:0] iv;
  logic [STAMP_W-1:0] wpeak_new;
  logic [STAMP_W-1:0] gpeak_new;
  logic [WC_W:0]      trial;
  logic [WC_W:0]      diff;
  logic               fits;
  logic [STAMP_W-1:0] mean_sat;

  // wrap-corrected elapsed time
  assign iv = (stamp_r >= last_r) ? (stamp_r - last_r) : (stamp_r + (tmax_r - last_r));
  assign wpeak_new = (iv > wpeak_r) ? iv : wpeak_r;
  assign gpeak_new = (iv > gpeak_r) ? iv : gpeak_r;

  // restoring divide, one quotient bit per step
  assign trial    = {rem_r, quo_r[SUM_W-1]};
  assign diff     = trial - {1'b0, wc_r};
  assign fits     = (trial >= {1'b0, wc_r});
  assign mean_sat = (|quo_r[SUM_W-1:STAMP_W]) ? '1 : quo_r[STAMP_W-1:0];

  assign status.is_mark  = cmd_r;
  assign status.no_close = (wc_r == '0) || (CMP_W'(count_r) != CMP_W'(wc_r));
  assign status.div_more = (dcnt_r != '0);
  assign status.out_busy = out_valid_r & ~out_ready;

  assign out_valid = out_valid_r;

  always_ff @(posedge clk) begin
    if (ctl.accept && in_valid) begin
      cmd_r   <= in_cmd;
      stamp_r <= in_timestamp;
    end
    case (ctl.op)
      OP_UPDATE: begin
        iv_r   <= iv;
        wmax_r <= wpeak_new;
        done_r <= 1'b0;
      end
      OP_DIV_INIT: begin
        quo_r   <= sum_r;
        rem_r   <= '0;
        dcnt_r  <= DCNT_W'(SUM_W - 1);
        total_r <= sum_r;
        done_r  <= 1'b1;
      end
      OP_DIV_STEP: begin
        rem_r  <= fits ? diff[WC_W-1:0] : trial[WC_W-1:0];
        quo_r  <= {quo_r[SUM_W-2:0], fits};
        dcnt_r <= dcnt_r - DCNT_W'(1);
      end
      OP_EMIT: begin
        out_interval     <= iv_r;
        out_window_done  <= done_r;
        out_window_mean  <= done_r ? mean_sat : '0;
        out_window_total <= done_r ? total_r : '0;
        out_window_max   <= wmax_r;
        out_global_max   <= gpeak_r;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wc_r        <= '0;
      tmax_r      <= '1;
      last_r      <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      wpeak_r     <= '0;
      gpeak_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_WINDOW_COUNT) begin
          wc_r <= cfg_data[WC_W-1:0];
        end else if (cfg_index == REG_TIMER_MAX) begin
          tmax_r <= cfg_data[STAMP_W-1:0];
        end
      end
      case (ctl.op)
        OP_RESTART: begin
          last_r  <= stamp_r;
          count_r <= '0;
          sum_r   <= '0;
          wpeak_r <= '0;
          gpeak_r <= '0;
        end
        OP_UPDATE: begin
          last_r  <= stamp_r;
          count_r <= count_r + COUNT_BITS'(1);
          sum_r   <= sum_r + SUM_W'(iv);
          wpeak_r <= wpeak_new;
          gpeak_r <= gpeak_new;
        end
        OP_DIV_INIT: begin
          count_r <= '0;
          sum_r   <= '0;
          wpeak_r <= '0;
        end
        default: begin
        end
      endcase
      if (ctl.op == OP_EMIT) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

FILE: verif/loop_interval_statistics_tb.sv
`timescale 1ns / 1ps

module loop_interval_statistics_tb;
  import lis_pkg::*;

  localparam logic CMD_RESTART = 1'b0;
  localparam logic CMD_MARK    = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = CFG_IDX_W'(3);

  localparam int STALL_LIMIT     = 2000;
  localparam int HOLD_CYCLES     = 300;
  localparam int IDLE_SETTLE     = 8;
  localparam int END_SETTLE      = 80;
  localparam int N_PHASES        = 8;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int HOLD_PHASE      = 6;
  localparam int PAUSE_PHASE     = 2;
  localparam int MAX_PRINTS      = 30;

  typedef struct packed {
    logic [STAMP_W-1:0] interval;
    logic               done;
    logic [STAMP_W-1:0] mean;
    logic [SUM_W-1:0]   total;
    logic [STAMP_W-1:0] wmax;
    logic [STAMP_W-1:0] gmax;
  } stats_res_t;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] data;
    logic                  cmd;
    logic [STAMP_W-1:0]    ts;
    logic                  pin;
    stats_res_t            res;
  } plan_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic                  in_cmd;
  logic [STAMP_W-1:0]    in_timestamp;
  logic                  out_valid;
  logic                  out_ready;
  logic [STAMP_W-1:0]    out_interval;
  logic                  out_window_done;
  logic [STAMP_W-1:0]    out_window_mean;
  logic [SUM_W-1:0]      out_window_total;
  logic [STAMP_W-1:0]    out_window_max;
  logic [STAMP_W-1:0]    out_global_max;

  // pinned expectation travels with the beat
  logic       in_pin;
  stats_res_t in_pin_res;

  // predictor copy of the block
  logic [WC_W-1:0]    win_len;
  logic [STAMP_W-1:0] wrap_top;
  logic [STAMP_W-1:0] prev_stamp;
  logic [WC_W-1:0]    marks_seen;
  logic [SUM_W-1:0]   window_sum;
  logic [STAMP_W-1:0] window_hi;
  logic [STAMP_W-1:0] overall_hi;

  stats_res_t results_due[$];
  plan_row_t  plan[$];

  int  errors;
  int  n_items;
  int  n_results;
  int  n_closes;
  int  n_wraps;
  int  n_cfg;
  int  idle_cycles;
  bit  hold_req;
  bit  send_burst;
  bit  recv_burst;

  loop_interval_statistics dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_cmd           (in_cmd),
    .in_timestamp     (in_timestamp),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_interval     (out_interval),
    .out_window_done  (out_window_done),
    .out_window_mean  (out_window_mean),
    .out_window_total (out_window_total),
    .out_window_max   (out_window_max),
    .out_global_max   (out_global_max)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    if (idx == REG_WINDOW_COUNT) begin
      win_len = data[WC_W-1:0];
    end else if (idx == REG_TIMER_MAX) begin
      wrap_top = data[STAMP_W-1:0];
    end
  endtask

  task automatic track_interval(input logic cmd, input logic [STAMP_W-1:0] ts,
                                output bit has, output stats_res_t r);
    logic [STAMP_W-1:0] iv;
    logic [SUM_W-1:0]   q;
    r = '0;
    has = 1'b0;
    if (cmd == CMD_RESTART) begin
      prev_stamp = ts;
      marks_seen = '0;
      window_sum = '0;
      window_hi  = '0;
      overall_hi = '0;
    end else begin
      if (ts >= prev_stamp) begin
        iv = ts - prev_stamp;
      end else begin
        iv = ts + (wrap_top - prev_stamp);
        n_wraps++;
      end
      prev_stamp = ts;
      if (iv > window_hi) window_hi = iv;
      if (iv > overall_hi) overall_hi = iv;
      window_sum = window_sum + SUM_W'(iv);
      marks_seen = marks_seen + 1'b1;
      r.interval = iv;
      r.wmax     = window_hi;
      r.gmax     = overall_hi;
      if (win_len != '0 && marks_seen == win_len) begin
        r.done  = 1'b1;
        r.total = window_sum;
        q = window_sum / SUM_W'(win_len);
        r.mean = (q > SUM_W'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : q[STAMP_W-1:0];
        marks_seen = '0;
        window_sum = '0;
        window_hi  = '0;
        n_closes++;
      end
      has = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (errors < MAX_PRINTS)
      $display("mismatch on result %0d: %s got %h want %h", n_results, what, got, want);
    errors++;
  endtask

  task automatic check_field(input string what, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  always @(posedge clk) begin : watch_beats
    stats_res_t want;
    stats_res_t pred;
    bit         has;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) apply_reg(cfg_index, cfg_data);
      if (in_valid && in_ready) begin
        track_interval(in_cmd, in_timestamp, has, pred);
        if (has) results_due.push_back(in_pin ? in_pin_res : pred);
      end
      if (out_valid && out_ready) begin
        if (results_due.size() == 0) begin
          report_mismatch("unexpected beat, interval", 64'(out_interval), 64'd0);
        end else begin
          want = results_due.pop_front();
          check_field("interval", 64'(out_interval), 64'(want.interval));
          check_field("window_done", 64'(out_window_done), 64'(want.done));
          check_field("window_mean", 64'(out_window_mean), 64'(want.mean));
          check_field("window_total", 64'(out_window_total), 64'(want.total));
          check_field("window_max", 64'(out_window_max), 64'(want.wmax));
          check_field("global_max", 64'(out_global_max), 64'(want.gmax));
        end
        n_results++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 20);
    return $urandom_range(40, 150);
  endfunction

  function automatic logic [STAMP_W-1:0] next_stamp(input logic [STAMP_W-1:0] cur,
                                                    input logic [STAMP_W-1:0] top);
    logic [STAMP_W:0]   nxt;
    logic [STAMP_W-1:0] step;
    int                 r;
    r = $urandom_range(0, 99);
    if (r < 5) step = '0;
    else if (r < 85) step = $urandom_range(1, 4000);
    else if (r < 97) step = $urandom_range(4001, 2000000);
    else step = $urandom;
    nxt = {1'b0, cur} + {1'b0, step};
    if (nxt > {1'b0, top}) nxt = nxt % ({1'b0, top} + 1'b1);
    return nxt[STAMP_W-1:0];
  endfunction

  // receiver: random stalls, one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (!recv_burst && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (gap_len() + 1) @(posedge clk);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_beat(input logic cmd, input logic [STAMP_W-1:0] ts, input logic pin,
                           input stats_res_t res);
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_timestamp <= ts;
    in_pin       <= pin;
    in_pin_res   <= res;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    n_items++;
  endtask

  task automatic pause_sender(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic wait_results_done();
    @(posedge clk);
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    wait_results_done();
    repeat (IDLE_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    n_cfg++;
    @(posedge clk);
  endtask

  task automatic add_item(input logic cmd, input logic [STAMP_W-1:0] ts);
    plan_row_t row;
    row      = '0;
    row.kind = ROW_ITEM;
    row.cmd  = cmd;
    row.ts   = ts;
    plan.push_back(row);
  endtask

  task automatic add_pin(input logic [STAMP_W-1:0] ts, input logic [STAMP_W-1:0] iv,
                         input logic done, input logic [STAMP_W-1:0] mean,
                         input logic [SUM_W-1:0] total, input logic [STAMP_W-1:0] wmax,
                         input logic [STAMP_W-1:0] gmax);
    plan_row_t row;
    row              = '0;
    row.kind         = ROW_ITEM;
    row.cmd          = CMD_MARK;
    row.ts           = ts;
    row.pin          = 1'b1;
    row.res.interval = iv;
    row.res.done     = done;
    row.res.mean     = mean;
    row.res.total    = total;
    row.res.wmax     = wmax;
    row.res.gmax     = gmax;
    plan.push_back(row);
  endtask

  task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    plan_row_t row;
    row      = '0;
    row.kind = ROW_CFG;
    row.idx  = idx;
    row.data = data;
    plan.push_back(row);
  endtask

  initial begin
    logic [CFG_DATA_W-1:0] win;
    logic [STAMP_W-1:0]    top;
    logic [STAMP_W-1:0]    cur;
    logic [STAMP_W-1:0]    ts;
    logic                  cmd;
    int                    roll;

    errors = 0;
    n_items = 0;
    n_results = 0;
    n_closes = 0;
    n_wraps = 0;
    n_cfg = 0;
    hold_req = 1'b0;
    send_burst = 1'b0;
    recv_burst = 1'b0;
    win_len = '0;
    wrap_top = '1;
    prev_stamp = '0;
    marks_seen = '0;
    window_sum = '0;
    window_hi = '0;
    overall_hi = '0;

    rst_n        <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    in_cmd       <= CMD_RESTART;
    in_timestamp <= '0;
    in_pin       <= 1'b0;
    in_pin_res   <= '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values, stamp extremes, wrap with full-range top
    add_pin(32'h0000_0000, 32'h0, 1'b0, 32'h0, 56'h0, 32'h0, 32'h0);
    add_pin(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 32'h0, 56'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_pin(32'h0000_0000, 32'h0, 1'b0, 32'h0, 56'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    add_item(CMD_RESTART, 32'h0);
    add_pin(32'h0000_0001, 32'h1, 1'b0, 32'h0, 56'h0, 32'h1, 32'h1);
    // upper data bits above the count width are dropped
    add_cfg(REG_WINDOW_COUNT, 32'hFF00_0003);
    add_cfg(REG_TIMER_MAX, 32'd999);
    add_cfg(REG_SPARE_LO, 32'hA5A5_5A5A);
    add_cfg(REG_SPARE_HI, 32'h5A5A_A5A5);
    add_item(CMD_RESTART, 32'd100);
    add_pin(32'd110, 32'd10, 1'b0, 32'd0, 56'd0, 32'd10, 32'd10);
    add_pin(32'd130, 32'd20, 1'b0, 32'd0, 56'd0, 32'd20, 32'd20);
    add_pin(32'd160, 32'd30, 1'b1, 32'd20, 56'd60, 32'd30, 32'd30);
    add_pin(32'd5, 32'd844, 1'b0, 32'd0, 56'd0, 32'd844, 32'd844);
    // window lowered to the running count, so the next mark runs past it
    add_cfg(REG_WINDOW_COUNT, 32'd1);
    add_item(CMD_MARK, 32'd10);
    add_item(CMD_RESTART, 32'd0);
    add_pin(32'd7, 32'd7, 1'b1, 32'd7, 56'd7, 32'd7, 32'd7);
    add_cfg(REG_WINDOW_COUNT, 32'h00FF_FFFF);
    add_cfg(REG_TIMER_MAX, 32'd0);
    add_item(CMD_MARK, 32'd3);
    add_item(CMD_MARK, 32'hFFFF_FFFF);
    add_cfg(REG_WINDOW_COUNT, 32'd2);
    add_cfg(REG_TIMER_MAX, 32'hFFFF_FFFF);
    add_item(CMD_RESTART, 32'hFFFF_FFFF);
    add_item(CMD_MARK, 32'hFFFF_FFFE);
    add_item(CMD_MARK, 32'hFFFF_FFFD);

    foreach (plan[i]) begin
      if (plan[i].kind == ROW_CFG) begin
        wait_drained();
        write_reg(plan[i].idx, plan[i].data);
      end else begin
        send_beat(plan[i].cmd, plan[i].ts, plan[i].pin, plan[i].res);
        pause_sender(gap_len());
      end
    end

    cur = 32'hFFFF_FFFD;
    for (int p = 0; p < N_PHASES; p++) begin
      wait_drained();
      case (p)
        0: begin win = 32'd4; top = 32'hFFFF_FFFF; end
        1: begin win = 32'd1; top = $urandom; end
        2: begin win = 32'd0; top = 32'd999999; end
        3: begin win = 32'h00FF_FFFF; top = 32'd0; end
        4: begin win = $urandom_range(2, 40); top = $urandom; end
        5: begin win = {8'($urandom), 24'd6}; top = 32'd65535; end
        6: begin win = 32'd16; top = 32'hFFFF_FFFF; end
        default: begin win = 32'd3; top = $urandom_range(1000, 100000); end
      endcase
      write_reg(REG_WINDOW_COUNT, win);
      write_reg(REG_TIMER_MAX, top);
      write_reg(p[0] ? REG_SPARE_HI : REG_SPARE_LO, $urandom);
      send_burst = (p == 3) || (p == HOLD_PHASE);
      recv_burst = (p == 4);
      if (p == HOLD_PHASE) hold_req = 1'b1;
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        if (p == PAUSE_PHASE && k == ITEMS_PER_PHASE / 2) begin
          in_valid <= 1'b0;
          wait_results_done();
        end
        roll = $urandom_range(0, 99);
        if (roll < 6) begin
          cmd = CMD_RESTART;
          ts  = $urandom_range(0, top);
        end else if (roll < 14) begin
          cmd = 1'($urandom_range(0, 1));
          ts  = $urandom;
        end else begin
          cmd = CMD_MARK;
          ts  = next_stamp(cur, top);
        end
        cur = ts;
        send_beat(cmd, ts, 1'b0, '0);
        pause_sender(send_burst ? 0 : gap_len());
      end
    end

    in_valid <= 1'b0;
    wait_results_done();
    repeat (END_SETTLE) @(posedge clk);
    $display("covered %0d input beats, %0d results, %0d closed windows, %0d wrapped intervals",
             n_items, n_results, n_closes, n_wraps);
    $display("%0d register writes over %0d settings, %0d mismatches",
             n_cfg, N_PHASES, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
rtl/lis_pkg.sv
rtl/lis_seq.sv
rtl/lis_dp.sv
rtl/loop_interval_statistics.sv
verif/loop_interval_statistics_tb.sv
